### sv/bgsr_pkg.sv
// Shared types, widths, reset values and codes for the battery guard.
// No dependencies; every other file imports this package.
package bgsr_pkg;

    localparam int CODE_W           = 10;
    localparam int FRAME_CODES      = 8;
    localparam int NUM_CHANNELS_DEF = 8;
    localparam int GAIN_W           = 16;
    localparam int OFFSET_W         = 24;
    localparam int LEVEL_W          = 8;
    localparam int BYTE_W           = 8;
    localparam int Q_SHIFT          = 16;
    localparam int PROD_W           = CODE_W + GAIN_W;
    localparam int CFG_IDX_W        = 4;
    localparam int CFG_DATA_W       = 24;

    // channel slots inside a frame
    localparam int CH_TEMP  = 0;
    localparam int CH_CELL0 = 2;

    localparam logic [CODE_W-1:0]   VCC_TRIP_RST  = CODE_W'(441);
    localparam logic [CODE_W-1:0]   TEMP_TRIP_RST = CODE_W'(650);
    localparam logic [GAIN_W-1:0]   DAC_GAIN_RST  = GAIN_W'(30308);
    localparam logic [OFFSET_W-1:0] DAC_OFFS_RST  = OFFSET_W'(2673869);
    localparam logic [LEVEL_W-1:0]  DAC_LEVEL_RST = '1;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_VCC_TRIP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_TRIP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DAC_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DAC_OFFS  = CFG_IDX_W'(3);

    // item kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_CMD   = 1'b1;

    // SPI command bytes
    localparam logic [BYTE_W-1:0] CMD_NEXT    = BYTE_W'(0);
    localparam logic [BYTE_W-1:0] CMD_RESTART = BYTE_W'(1);
    localparam logic [BYTE_W-1:0] CMD_TRIP    = BYTE_W'(2);
    localparam logic [BYTE_W-1:0] CMD_LED_ON  = BYTE_W'(3);
    localparam logic [BYTE_W-1:0] CMD_LED_OFF = BYTE_W'(4);

    typedef logic [FRAME_CODES-1:0][CODE_W-1:0] frame_codes_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               supply_low;
        logic               over_temp;
    } level_res_t;

    typedef struct packed {
        logic frame_we;
        logic rd_en;
        logic rd_restart;
    } store_ctl_t;

endpackage

### sv/bgsr_level.sv
// Frame math: trip compares and DAC level from the cell 0 code via Q16 gain and offset.
// Depends on bgsr_pkg.
module bgsr_level
    import bgsr_pkg::*;
(
    input  logic [CODE_W-1:0]   cell0_code,
    input  logic [CODE_W-1:0]   temp_code,
    input  logic [CODE_W-1:0]   vcc_trip,
    input  logic [CODE_W-1:0]   temp_trip,
    input  logic [GAIN_W-1:0]   gain,
    input  logic [OFFSET_W-1:0] offset,
    output level_res_t          res
);

    localparam int LVL_FULL_W = PROD_W - Q_SHIFT;

    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     diff;
    logic                  above;
    logic [LVL_FULL_W-1:0] lvl_full;
    logic                  sat;
    logic [LEVEL_W-1:0]    lvl;
    logic                  slow;
    logic                  hot;

    always_comb
    begin
        prod     = PROD_W'(cell0_code) * PROD_W'(gain);
        above    = prod > PROD_W'(offset);
        diff     = prod - PROD_W'(offset);
        lvl_full = diff[PROD_W-1:Q_SHIFT];
        sat      = |lvl_full[LVL_FULL_W-1:LEVEL_W];
        if (!above)
        begin
            lvl = '0;
        end
        else if (sat)
        begin
            lvl = '1;
        end
        else
        begin
            lvl = lvl_full[LEVEL_W-1:0];
        end
        slow = cell0_code <= vcc_trip;
        hot  = temp_code <= temp_trip;
        res.supply_low = slow;
        res.over_temp  = hot;
        res.level      = (slow || hot) ? '0 : lvl;
    end

endmodule

### sv/bgsr_store.sv
// Channel store and byte read pointer for the SPI readout.
// Depends on bgsr_pkg.
module bgsr_store
    import bgsr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  store_ctl_t         ctl,
    input  frame_codes_t       codes,
    output logic [BYTE_W-1:0]  reply_byte
);

    localparam int READ_BYTES = 2 * NUM_CHANNELS;
    localparam int PTR_W      = $clog2(READ_BYTES);
    localparam int CH_W       = PTR_W - 1;

    logic [CODE_W-1:0] store_reg [NUM_CHANNELS];
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [PTR_W-1:0]  pos;
    logic [PTR_W:0]    pos_inc;
    logic [CH_W-1:0]   ch;
    logic [CODE_W-1:0] code;

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        if (i < FRAME_CODES)
        begin : g_wr
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    store_reg[i] <= '0;
                end
                else if (ctl.frame_we)
                begin
                    store_reg[i] <= codes[i];
                end
            end
        end
        else
        begin : g_zero
            // channels beyond the frame are never written
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    store_reg[i] <= '0;
                end
            end
        end
    end

    always_comb
    begin
        pos     = ctl.rd_restart ? '0 : ptr_reg;
        ch      = pos[PTR_W-1:1];
        code    = store_reg[ch];
        // low byte first, then the top two bits
        reply_byte = pos[0] ? BYTE_W'(code[CODE_W-1:BYTE_W]) : code[BYTE_W-1:0];
        pos_inc = {1'b0, pos} + (PTR_W+1)'(1);
        if (pos_inc == (PTR_W+1)'(READ_BYTES))
        begin
            ptr_next = '0;
        end
        else
        begin
            ptr_next = pos_inc[PTR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
        end
        else if (ctl.rd_en)
        begin
            ptr_reg <= ptr_next;
        end
    end

endmodule

### sv/battery_guard_with_spi_readout.sv
// Battery guard: ADC frames set the comparator DAC level, SPI commands read
// back stored codes and drive the LED. Depends on bgsr_pkg, bgsr_level, bgsr_store.
// Path: an accepted item is held in the input register, then moved to the result
// register, which raises out_valid; the result is taken when out_ready is high.
// Throughput: one word per cycle while out_ready holds; the item in the input register
// is processed in the cycle the result register is free or being taken.
// Reset (async, active low): registers at defaults, store zero, DAC level 255,
// LED off, blinker on, both pipeline registers empty.
module battery_guard_with_spi_readout
    import bgsr_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [CODE_W-1:0]     temp_code,
    input  logic [CODE_W-1:0]     current_code,
    input  logic [CODE_W-1:0]     cell0_code,
    input  logic [CODE_W-1:0]     cell1_code,
    input  logic [CODE_W-1:0]     cell2_code,
    input  logic [CODE_W-1:0]     cell3_code,
    input  logic [CODE_W-1:0]     cell4_code,
    input  logic [CODE_W-1:0]     cell5_code,
    input  logic [BYTE_W-1:0]     spi_byte,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  reply_valid,
    output logic [BYTE_W-1:0]     reply_byte,
    output logic [LEVEL_W-1:0]    dac_level,
    output logic                  supply_low,
    output logic                  over_temperature,
    output logic                  led_on,
    output logic                  blink_enabled
);

    // configuration
    logic [CODE_W-1:0]   vcc_trip_reg;
    logic [CODE_W-1:0]   temp_trip_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] offset_reg;

    // input register
    logic                in_valid_reg;
    logic                kind_reg;
    logic [BYTE_W-1:0]   spi_reg;
    frame_codes_t        codes_reg;

    // block state
    logic                led_reg;
    logic                led_next;
    logic                blink_reg;
    logic                blink_next;
    logic [LEVEL_W-1:0]  dac_reg;
    logic [LEVEL_W-1:0]  dac_next;

    // result register
    logic                out_valid_reg;
    logic                reply_valid_reg;
    logic                reply_valid_next;
    logic [BYTE_W-1:0]   reply_byte_reg;
    logic [BYTE_W-1:0]   reply_byte_next;
    logic                slow_reg;
    logic                hot_reg;

    logic                advance;
    logic                in_take;
    level_res_t          lvl_res;
    store_ctl_t          st_ctl;
    logic [BYTE_W-1:0]   st_byte;
    logic                is_frame;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign in_take   = in_valid && in_ready;
    assign is_frame  = kind_reg == KIND_FRAME;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcc_trip_reg  <= VCC_TRIP_RST;
            temp_trip_reg <= TEMP_TRIP_RST;
            gain_reg      <= DAC_GAIN_RST;
            offset_reg    <= DAC_OFFS_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_VCC_TRIP:  vcc_trip_reg  <= cfg_data[CODE_W-1:0];
                REG_TEMP_TRIP: temp_trip_reg <= cfg_data[CODE_W-1:0];
                REG_DAC_GAIN:  gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_DAC_OFFS:  offset_reg    <= cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            spi_reg   <= spi_byte;
            codes_reg <= {cell5_code, cell4_code, cell3_code, cell2_code,
                          cell1_code, cell0_code, current_code, temp_code};
        end
    end

    bgsr_level u_level (
        .cell0_code (codes_reg[CH_CELL0]),
        .temp_code  (codes_reg[CH_TEMP]),
        .vcc_trip   (vcc_trip_reg),
        .temp_trip  (temp_trip_reg),
        .gain       (gain_reg),
        .offset     (offset_reg),
        .res        (lvl_res)
    );

    always_comb
    begin
        st_ctl.frame_we   = advance && is_frame;
        st_ctl.rd_en      = advance && !is_frame &&
                            (spi_reg == CMD_NEXT || spi_reg == CMD_RESTART);
        st_ctl.rd_restart = spi_reg == CMD_RESTART;
    end

    bgsr_store #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (st_ctl),
        .codes      (codes_reg),
        .reply_byte (st_byte)
    );

    always_comb
    begin
        led_next         = led_reg;
        blink_next       = blink_reg;
        dac_next         = dac_reg;
        reply_valid_next = 1'b0;
        reply_byte_next  = '0;
        if (is_frame)
        begin
            dac_next = lvl_res.level;
        end
        else
        begin
            // first command stops the blinker and clears the LED, unless it is LED_ON
            if (blink_reg)
            begin
                blink_next = 1'b0;
                led_next   = 1'b0;
            end
            case (spi_reg) inside
                CMD_NEXT, CMD_RESTART:
                begin
                    reply_valid_next = 1'b1;
                    reply_byte_next  = st_byte;
                end
                CMD_TRIP:    dac_next = '0;
                CMD_LED_ON:  led_next = 1'b1;
                CMD_LED_OFF: led_next = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_reg       <= 1'b0;
            blink_reg     <= 1'b1;
            dac_reg       <= DAC_LEVEL_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                led_reg       <= led_next;
                blink_reg     <= blink_next;
                dac_reg       <= dac_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reply_valid_reg <= reply_valid_next;
            reply_byte_reg  <= reply_byte_next;
            slow_reg        <= is_frame && lvl_res.supply_low;
            hot_reg         <= is_frame && lvl_res.over_temp;
        end
    end

    assign out_valid        = out_valid_reg;
    assign reply_valid      = reply_valid_reg;
    assign reply_byte       = reply_byte_reg;
    assign dac_level        = dac_reg;
    assign supply_low       = slow_reg;
    assign over_temperature = hot_reg;
    assign led_on           = led_reg;
    assign blink_enabled    = blink_reg;

    a_trip_zeroes_dac: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (slow_reg || hot_reg) |-> dac_reg == '0)
        else $error("tripped frame left nonzero DAC level");

    a_reply_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && reply_valid_reg |-> !slow_reg && !hot_reg)
        else $error("readout word carries trip flags");

    a_blink_stays_off: assert property (@(posedge clk) disable iff (!rst_n)
        !blink_reg |=> !blink_reg)
        else $error("blinker restarted");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a full pipeline");

endmodule
